### hdl/bpq_pkg.sv
// Shared types and codes for the bounded priority queue.
`timescale 1ns / 1ps

package bpq_pkg;

  // Width of the value and priority fields
  localparam int unsigned DataW = 32;
  // Width of the fill field on the result channel
  localparam int unsigned FillW = 4;

  // Operation codes on the input channel
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_PEEK   = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One stored entry
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
  } entry_t;

  // Per-cell control from the queue controller
  typedef struct packed {
    logic ins;       // insert shifts the chain this cycle
    logic occupied;  // cell lies below the occupancy
  } cell_ctrl_t;

endpackage

### hdl/bpq_cell.sv
// One cell of the sorted chain: holds an entry, keeps, loads new or takes its lower neighbor.
`timescale 1ns / 1ps

module bpq_cell (
  input  logic                clk_i,
  input  bpq_pkg::cell_ctrl_t ctrl_i,
  input  bpq_pkg::entry_t     new_i,
  input  bpq_pkg::entry_t     prev_i,
  input  logic                prev_lt_i,
  output bpq_pkg::entry_t     entry_o,
  output logic                lt_o
);

  bpq_pkg::entry_t entry_q;

  // Held entry ranks strictly below the incoming one; equal priority moves up
  assign lt_o    = ctrl_i.occupied && (entry_q.prio < new_i.prio);
  assign entry_o = entry_q;

  // Keep when below the insert point, load at the point, shift up above it
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ins && !lt_o) begin
      entry_q <= prev_lt_i ? new_i : prev_i;
    end
  end

endmodule

### hdl/bounded_priority_queue.sv
// Top level: bounded priority queue built as a sorted chain of cells.
`timescale 1ns / 1ps

//  channel | signals                                     | direction
//  --------+---------------------------------------------+-----------
//  in      | in_valid_i, in_stall_o, op_i, value_i, prio_i | item in
//  out     | out_valid_o, out_stall_i, status_o,          | item out
//          | out_value_o, out_prio_o, fill_o, last_o      |
//
// Insert, delete and peek each give one result item; the chain compares and shifts all
// cells in parallel. A list emits one item per cycle for each held entry while the
// output is not stalled, and no input is taken until its last item is registered.
// Reset clears the occupancy and output valid; cell contents are not reset.
// A stalled output item holds in the output register; the next input is taken
// in the same cycle that register drains.

module bounded_priority_queue #(
  parameter int unsigned CAPACITY = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         op_i,
  input  logic signed [bpq_pkg::DataW-1:0]   value_i,
  input  logic signed [bpq_pkg::DataW-1:0]   prio_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         status_o,
  output logic signed [bpq_pkg::DataW-1:0]   out_value_o,
  output logic signed [bpq_pkg::DataW-1:0]   out_prio_o,
  output logic [bpq_pkg::FillW-1:0]          fill_o,
  output logic                               last_o
);

  localparam int unsigned OccW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [OccW-1:0] occ_q, occ_d;
  logic            listing_q, listing_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic                  out_valid_q, out_valid_d;
  bpq_pkg::status_e      status_q, status_d;
  bpq_pkg::entry_t       res_q, res_d;
  logic [OccW-1:0]       res_fill_q, res_fill_d;
  logic                  last_q, last_d;

  logic            slot_free, in_acc, full, empty, ins_en, list_last, emit;
  logic [OccW-1:0] occ_m1;
  logic [IdxW-1:0] rd_idx;
  bpq_pkg::op_e    op;
  bpq_pkg::entry_t new_entry, rd_entry;
  logic [OccW+bpq_pkg::FillW-1:0] fill_wide;

  bpq_pkg::entry_t    cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;

  // Handshake and status terms
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = listing_q || !slot_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign op         = bpq_pkg::op_e'(op_i);
  assign full       = (occ_q == OccW'(CAPACITY));
  assign empty      = (occ_q == '0);
  assign ins_en     = in_acc && (op == bpq_pkg::OP_INSERT) && !full;
  assign new_entry  = '{value: value_i, prio: prio_i};

  // Read port: list walks up from cell 0, otherwise the top held cell
  assign occ_m1    = occ_q - OccW'(1);
  assign rd_idx    = listing_q ? idx_q : occ_m1[IdxW-1:0];
  assign rd_entry  = cell_entry[rd_idx];
  assign list_last = (OccW'(idx_q) + OccW'(1)) == occ_q;
  assign emit      = listing_q && slot_free;

  // Cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bpq_pkg::cell_ctrl_t ctrl;
    bpq_pkg::entry_t     prev_entry;
    logic                prev_lt;

    assign ctrl.ins      = ins_en;
    assign ctrl.occupied = occ_q > OccW'(i);

    if (i == 0) begin : g_first
      assign prev_entry = new_entry;
      assign prev_lt    = 1'b1;
    end else begin : g_rest
      assign prev_entry = cell_entry[i-1];
      assign prev_lt    = cell_lt[i-1];
    end

    bpq_cell u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .new_i     (new_entry),
      .prev_i    (prev_entry),
      .prev_lt_i (prev_lt),
      .entry_o   (cell_entry[i]),
      .lt_o      (cell_lt[i])
    );
  end

  // Controller next state and result register
  always_comb begin
    occ_d       = occ_q;
    listing_d   = listing_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    status_d    = status_q;
    res_d       = res_q;
    res_fill_d  = res_fill_q;
    last_d      = last_q;

    if (in_acc) begin
      out_valid_d = 1'b1;
      status_d    = bpq_pkg::ST_OK;
      res_d       = '0;
      last_d      = 1'b1;
      unique case (op)
        bpq_pkg::OP_INSERT: begin
          if (full) begin
            status_d = bpq_pkg::ST_FULL;
          end else begin
            occ_d = occ_q + OccW'(1);
          end
        end
        bpq_pkg::OP_DELETE: begin
          if (empty) begin
            status_d = bpq_pkg::ST_EMPTY;
          end else begin
            occ_d = occ_m1;
            res_d = rd_entry;
          end
        end
        bpq_pkg::OP_PEEK: begin
          if (empty) begin
            status_d = bpq_pkg::ST_EMPTY;
          end else begin
            res_d = rd_entry;
          end
        end
        bpq_pkg::OP_LIST: begin
          if (empty) begin
            status_d = bpq_pkg::ST_EMPTY;
          end else begin
            out_valid_d = 1'b0;
            listing_d   = 1'b1;
            idx_d       = '0;
          end
        end
        default: begin
          status_d = bpq_pkg::ST_OK;
        end
      endcase
      res_fill_d = occ_d;
    end else if (emit) begin
      out_valid_d = 1'b1;
      status_d    = bpq_pkg::ST_OK;
      res_d       = rd_entry;
      res_fill_d  = occ_q;
      last_d      = list_last;
      idx_d       = idx_q + IdxW'(1);
      if (list_last) begin
        listing_d = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      listing_q   <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      listing_q   <= listing_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    res_q      <= res_d;
    res_fill_q <= res_fill_d;
    last_q     <= last_d;
  end

  // Outputs; fill is the occupancy masked to the field width
  assign fill_wide   = {{bpq_pkg::FillW{1'b0}}, res_fill_q};
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_value_o = res_q.value;
  assign out_prio_o  = res_q.prio;
  assign fill_o      = fill_wide[bpq_pkg::FillW-1:0];
  assign last_o      = last_q;

  // Occupancy never exceeds the capacity
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(CAPACITY))
    else $error("occupancy above capacity");

  // A list in progress blocks new input
  a_list_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    listing_q |-> in_stall_o)
    else $error("input taken during list");

  // The final listed item ends the list
  a_list_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && list_last) |=> (!listing_q && last_o && out_valid_o))
    else $error("list did not end on its last item");

  // A successful insert grows the occupancy by one
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_en |=> (occ_q == $past(occ_q) + OccW'(1)))
    else $error("insert did not grow occupancy");

  // The list never changes the occupancy
  a_list_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    listing_q |=> $stable(occ_q))
    else $error("occupancy changed during list");

endmodule
